/* rtl/egr_pkg.sv */
// ----------------------------------------------------------------------------
// egr_pkg
// constants, types and the arctangent table of the geocentric radius block
// ----------------------------------------------------------------------------
package egr_pkg;

   localparam int TRIG_STEPS  = 32;
   localparam int LAT_W       = 29;
   localparam int AXIS_W      = 36;
   localparam int Q30_W       = 32;
   localparam int Q_FRAC      = 30;
   localparam int P_FRAC      = 32;
   localparam int CORDIC_W    = 64;
   localparam int CSR_INDEX_W = 2;

   typedef logic        [AXIS_W-1:0]  axis_type;
   typedef logic signed [Q30_W-1:0]   q30_type;
   typedef logic signed [LAT_W-1:0]   lat_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;

   localparam csr_index_type CSR_SEMI_MAJOR = 2'd0;
   localparam csr_index_type CSR_SEMI_MINOR = 2'd1;

   localparam axis_type SEMI_MAJOR_RESET = 36'd6378137000;
   localparam axis_type SEMI_MINOR_RESET = 36'd6356752314;

   localparam longint unsigned DEG_HALF_TURN  = 64'd180;
   localparam longint unsigned UDEG_PER_DEG   = 64'd1000000;
   localparam longint unsigned HALF_TURN_UDEG = DEG_HALF_TURN * UDEG_PER_DEG;
   localparam longint unsigned PI_Q60         = 64'h3243F6A8885A308D;
   localparam logic [34:0]     RAD_K          = 35'(PI_Q60 / HALF_TURN_UDEG);

   localparam logic [LAT_W-1:0] HALF_TURN    = LAT_W'(HALF_TURN_UDEG);
   localparam logic [LAT_W-1:0] QUARTER_TURN = LAT_W'(HALF_TURN_UDEG / 2);
   localparam logic [LAT_W-1:0] EIGHTH_TURN  = LAT_W'(HALF_TURN_UDEG / 4);

   localparam q30_type Q30_MAX = 32'sh7FFF_FFFF;
   localparam q30_type Q30_MIN = 32'sh8000_0000;

   // quotient of two positive values by shift and subtract
   function automatic longint series_quotient(input longint num, input int den);
      longint quo;
      longint rem;
      int     k;
      quo = 0;
      rem = 0;
      for (k = 62; k >= 0; k--) begin
         rem = (rem << 1) | ((num >>> k) & 64'sd1);
         quo = quo << 1;
         if (rem >= longint'(den)) begin
            rem = rem - longint'(den);
            quo = quo | 64'sd1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in q60 from the truncated series, with pi/4 taken directly for i = 0
   function automatic longint atan_q60(input int i);
      longint sum;
      longint term;
      int     n;
      logic   plus;
      sum  = 0;
      plus = 1'b1;
      if (i == 0) begin
         sum = longint'(PI_Q60 >> 2);
      end else begin
         for (n = 1; n * i <= 60; n += 2) begin
            term = series_quotient(longint'(1) << (60 - n * i), n);
            sum  = plus ? sum + term : sum - term;
            plus = !plus;
         end
      end
      return sum;
   endfunction

endpackage

/* rtl/ellipsoid_geocentric_radius.sv */
// ----------------------------------------------------------------------------
// ellipsoid_geocentric_radius
// geocentric radius, flattening and eccentricity squared of an ellipsoid
// ----------------------------------------------------------------------------
// An item (a latitude in microdegrees) is taken at a rising edge with start
// high and busy low. busy is high only while reset is applied and for the
// cycle after it, so a new item may follow in every cycle.
// Each result is shown for one cycle with rsp_strobe high; results keep item
// order and the receiver cannot stall the block.
// The latency is set by the pipeline depth: one stage per rotation step of
// the trig unit, one per quotient bit of the weight division and one per
// root bit of the square root.
// The axes are written on the csr_ port, index 0 for the semi-major axis and
// index 1 for the semi-minor axis; the user must write them only while no item
// is in flight, a rule that the block itself leaves unchecked. After a write or
// reset a small sequencer works out flattening and eccentricity squared.
// Reset loads the default axes and drops every item in flight.
// ----------------------------------------------------------------------------
module ellipsoid_geocentric_radius (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  egr_pkg::lat_type      req_latitude_udeg,
   output logic                  rsp_strobe,
   output egr_pkg::axis_type     rsp_radius_mm,
   output egr_pkg::q30_type      rsp_flattening_q30,
   output egr_pkg::q30_type      rsp_ecc_squared_q30,
   output logic                  rsp_math_error,
   input  logic                  csr_write_enable,
   input  egr_pkg::csr_index_type csr_index,
   input  egr_pkg::axis_type     csr_data
);
   import egr_pkg::*;

   localparam int DIV_STEPS  = P_FRAC + 1;
   localparam int SQRT_STEPS = AXIS_W;
   localparam int R2_W       = 2 * AXIS_W;
   localparam int LAST_TRIG  = TRIG_STEPS - 1;
   localparam int LAST_DIV   = DIV_STEPS - 1;
   localparam int LAST_SQRT  = SQRT_STEPS - 1;

   localparam logic [2:0] SEQ_PREP = 3'd0;
   localparam logic [2:0] SEQ_MUL  = 3'd1;
   localparam logic [2:0] SEQ_INIT = 3'd2;
   localparam logic [2:0] SEQ_DIV  = 3'd3;
   localparam logic [2:0] SEQ_DONE = 3'd4;

   // configuration
   axis_type semi_major_ff, semi_major_in;
   axis_type semi_minor_ff, semi_minor_in;
   logic     busy_ff;
   logic     accept;

   always_comb begin
      semi_major_in = semi_major_ff;
      semi_minor_in = semi_minor_ff;
      if (csr_write_enable && csr_index == CSR_SEMI_MAJOR) begin
         semi_major_in = csr_data;
      end
      if (csr_write_enable && csr_index == CSR_SEMI_MINOR) begin
         semi_minor_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_major_ff <= SEMI_MAJOR_RESET;
         semi_minor_ff <= SEMI_MINOR_RESET;
         busy_ff       <= 1'b1;
      end else begin
         semi_major_ff <= semi_major_in;
         semi_minor_ff <= semi_minor_in;
         busy_ff       <= 1'b0;
      end
   end

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // flattening and eccentricity sequencer
   logic [2:0]        seq_state_ff, seq_state_in;
   logic [4:0]        seq_cnt_ff, seq_cnt_in;
   logic              neg_ff, neg_in;
   axis_type          diff_ff, diff_in;
   logic [AXIS_W:0]   sum_ff, sum_in;
   logic [R2_W:0]     necc_ff, necc_in;
   logic [R2_W-1:0]   aa_ff, aa_in;
   logic [R2_W-1:0]   bb_ff, bb_in;
   logic              flat_sat_ff, flat_sat_in;
   logic              ecc_sat_ff, ecc_sat_in;
   logic [Q_FRAC:0]   flat_q_ff, flat_q_in;
   logic [Q_FRAC:0]   ecc_q_ff, ecc_q_in;
   logic [AXIS_W:0]   flat_rem_ff, flat_rem_in;
   logic [R2_W:0]     ecc_rem_ff, ecc_rem_in;
   logic [AXIS_W:0]   flat_rem2;
   logic [R2_W:0]     ecc_rem2;

   always_comb begin
      seq_state_in = seq_state_ff;
      seq_cnt_in   = seq_cnt_ff;
      neg_in       = neg_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      necc_in      = necc_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      flat_sat_in  = flat_sat_ff;
      ecc_sat_in   = ecc_sat_ff;
      flat_q_in    = flat_q_ff;
      ecc_q_in     = ecc_q_ff;
      flat_rem_in  = flat_rem_ff;
      ecc_rem_in   = ecc_rem_ff;
      flat_rem2    = flat_rem_ff << 1;
      ecc_rem2     = ecc_rem_ff << 1;
      case (seq_state_ff)
         SEQ_PREP: begin
            neg_in       = semi_minor_ff > semi_major_ff;
            diff_in      = neg_in ? semi_minor_ff - semi_major_ff
                                  : semi_major_ff - semi_minor_ff;
            sum_in       = (AXIS_W + 1)'(semi_major_ff) + (AXIS_W + 1)'(semi_minor_ff);
            seq_state_in = SEQ_MUL;
         end
         SEQ_MUL: begin
            necc_in      = (R2_W + 1)'(diff_ff) * (R2_W + 1)'(sum_ff);
            aa_in        = R2_W'(semi_major_ff) * R2_W'(semi_major_ff);
            bb_in        = R2_W'(semi_minor_ff) * R2_W'(semi_minor_ff);
            seq_state_in = SEQ_INIT;
         end
         SEQ_INIT: begin
            flat_sat_in = (AXIS_W + 1)'(diff_ff) >= {semi_major_ff, 1'b0};
            if ((AXIS_W + 1)'(diff_ff) >= (AXIS_W + 1)'(semi_major_ff)) begin
               flat_q_in   = (Q_FRAC + 1)'(1);
               flat_rem_in = (AXIS_W + 1)'(diff_ff) - (AXIS_W + 1)'(semi_major_ff);
            end else begin
               flat_q_in   = '0;
               flat_rem_in = (AXIS_W + 1)'(diff_ff);
            end
            ecc_sat_in = (R2_W + 2)'(necc_ff) >= (R2_W + 2)'({aa_ff, 1'b0});
            if (necc_ff >= (R2_W + 1)'(aa_ff)) begin
               ecc_q_in   = (Q_FRAC + 1)'(1);
               ecc_rem_in = necc_ff - (R2_W + 1)'(aa_ff);
            end else begin
               ecc_q_in   = '0;
               ecc_rem_in = necc_ff;
            end
            seq_cnt_in   = '0;
            seq_state_in = SEQ_DIV;
         end
         SEQ_DIV: begin
            if (flat_rem2 >= (AXIS_W + 1)'(semi_major_ff)) begin
               flat_q_in   = {flat_q_ff[Q_FRAC-1:0], 1'b1};
               flat_rem_in = flat_rem2 - (AXIS_W + 1)'(semi_major_ff);
            end else begin
               flat_q_in   = {flat_q_ff[Q_FRAC-1:0], 1'b0};
               flat_rem_in = flat_rem2;
            end
            if (ecc_rem2 >= (R2_W + 1)'(aa_ff)) begin
               ecc_q_in   = {ecc_q_ff[Q_FRAC-1:0], 1'b1};
               ecc_rem_in = ecc_rem2 - (R2_W + 1)'(aa_ff);
            end else begin
               ecc_q_in   = {ecc_q_ff[Q_FRAC-1:0], 1'b0};
               ecc_rem_in = ecc_rem2;
            end
            seq_cnt_in = seq_cnt_ff + 5'd1;
            if (seq_cnt_ff == 5'(Q_FRAC - 1)) begin
               seq_state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            seq_state_in = SEQ_DONE;
         end
         default: begin
            seq_state_in = SEQ_PREP;
         end
      endcase
      if (csr_write_enable) begin
         seq_state_in = SEQ_PREP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= SEQ_PREP;
         seq_cnt_ff   <= '0;
      end else begin
         seq_state_ff <= seq_state_in;
         seq_cnt_ff   <= seq_cnt_in;
      end
      neg_ff      <= neg_in;
      diff_ff     <= diff_in;
      sum_ff      <= sum_in;
      necc_ff     <= necc_in;
      aa_ff       <= aa_in;
      bb_ff       <= bb_in;
      flat_sat_ff <= flat_sat_in;
      ecc_sat_ff  <= ecc_sat_in;
      flat_q_ff   <= flat_q_in;
      ecc_q_ff    <= ecc_q_in;
      flat_rem_ff <= flat_rem_in;
      ecc_rem_ff  <= ecc_rem_in;
   end

   // angle folding
   logic [LAT_W-1:0] lat_raw, mag0, mag1, mag2, mag3;
   logic             fold_swap_in;
   logic             fold_valid_ff;
   logic             fold_swap_ff;
   logic [25:0]      fold_mag_ff;

   always_comb begin
      lat_raw      = req_latitude_udeg;
      mag0         = lat_raw[LAT_W-1] ? LAT_W'(0) - lat_raw : lat_raw;
      mag1         = (mag0 >= HALF_TURN) ? mag0 - HALF_TURN : mag0;
      mag2         = (mag1 > QUARTER_TURN) ? HALF_TURN - mag1 : mag1;
      fold_swap_in = mag2 > EIGHTH_TURN;
      mag3         = fold_swap_in ? QUARTER_TURN - mag2 : mag2;
   end

   // angle to q60 radians
   logic                       zed_valid_ff;
   logic                       zed_swap_ff;
   logic signed [CORDIC_W-1:0] zed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         zed_valid_ff  <= 1'b0;
      end else begin
         fold_valid_ff <= accept;
         zed_valid_ff  <= fold_valid_ff;
      end
      fold_swap_ff <= fold_swap_in;
      fold_mag_ff  <= mag3[25:0];
      zed_swap_ff  <= fold_swap_ff;
      zed_ff       <= $signed(CORDIC_W'(fold_mag_ff) * CORDIC_W'(RAD_K));
   end

   // rotation pipeline
   logic signed [CORDIC_W-1:0] cord_x_ff [0:TRIG_STEPS-1];
   logic signed [CORDIC_W-1:0] cord_y_ff [0:TRIG_STEPS-1];
   logic signed [CORDIC_W-1:0] cord_z_ff [0:TRIG_STEPS-1];
   logic signed [CORDIC_W-1:0] cord_x_in [0:TRIG_STEPS-1];
   logic signed [CORDIC_W-1:0] cord_y_in [0:TRIG_STEPS-1];
   logic signed [CORDIC_W-1:0] cord_z_in [0:TRIG_STEPS-1];
   logic [TRIG_STEPS-1:0]      cord_valid_ff;
   logic [TRIG_STEPS-1:0]      cord_swap_ff;

   for (genvar gi = 0; gi < TRIG_STEPS; gi++) begin : g_cordic
      localparam logic signed [CORDIC_W-1:0] ANGLE = atan_q60(gi);
      logic signed [CORDIC_W-1:0] xs, ys, zs;
      logic                       vs, ss;
      if (gi == 0) begin : g_head
         assign xs = CORDIC_W'(64'sd1 <<< 60);
         assign ys = '0;
         assign zs = zed_ff;
         assign vs = zed_valid_ff;
         assign ss = zed_swap_ff;
      end else begin : g_body
         assign xs = cord_x_ff[gi-1];
         assign ys = cord_y_ff[gi-1];
         assign zs = cord_z_ff[gi-1];
         assign vs = cord_valid_ff[gi-1];
         assign ss = cord_swap_ff[gi-1];
      end
      always_comb begin
         if (!zs[CORDIC_W-1]) begin
            cord_x_in[gi] = xs - (ys >>> gi);
            cord_y_in[gi] = ys + (xs >>> gi);
            cord_z_in[gi] = zs - ANGLE;
         end else begin
            cord_x_in[gi] = xs + (ys >>> gi);
            cord_y_in[gi] = ys - (xs >>> gi);
            cord_z_in[gi] = zs + ANGLE;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cord_valid_ff[gi] <= 1'b0;
         end else begin
            cord_valid_ff[gi] <= vs;
         end
         cord_swap_ff[gi] <= ss;
         cord_x_ff[gi]    <= cord_x_in[gi];
         cord_y_ff[gi]    <= cord_y_in[gi];
         cord_z_ff[gi]    <= cord_z_in[gi];
      end
   end

   // scaled cosine and sine terms
   logic signed [CORDIC_W-1:0] x_abs, y_abs;
   logic [26:0]                cm, sm;
   logic [62:0]                pu_in, pv_in;
   logic [62:0]                pu_ff, pv_ff;
   logic                       p1_valid_ff;

   always_comb begin
      x_abs = cord_x_ff[LAST_TRIG][CORDIC_W-1] ? -cord_x_ff[LAST_TRIG] : cord_x_ff[LAST_TRIG];
      y_abs = cord_y_ff[LAST_TRIG][CORDIC_W-1] ? -cord_y_ff[LAST_TRIG] : cord_y_ff[LAST_TRIG];
      cm    = cord_swap_ff[LAST_TRIG] ? y_abs[60:34] : x_abs[60:34];
      sm    = cord_swap_ff[LAST_TRIG] ? x_abs[60:34] : y_abs[60:34];
      pu_in = 63'(semi_major_ff) * 63'(cm);
      pv_in = 63'(semi_minor_ff) * 63'(sm);
   end

   // squares as partial products
   logic [63:0]  uull_ff, vvll_ff;
   logic [62:0]  uulh_ff, vvlh_ff;
   logic [61:0]  uuhh_ff, vvhh_ff;
   logic         p2_valid_ff, p2_zero_ff;
   logic [127:0] uu_ff, vv_ff;
   logic         p3_valid_ff, p3_zero_ff;
   logic [127:0] dnum_ff, dden_ff;
   logic         p4_valid_ff, p4_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cord_valid_ff[LAST_TRIG];
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
      pu_ff      <= pu_in;
      pv_ff      <= pv_in;
      uull_ff    <= 64'(pu_ff[31:0]) * 64'(pu_ff[31:0]);
      uulh_ff    <= 63'(pu_ff[31:0]) * 63'(pu_ff[62:32]);
      uuhh_ff    <= 62'(pu_ff[62:32]) * 62'(pu_ff[62:32]);
      vvll_ff    <= 64'(pv_ff[31:0]) * 64'(pv_ff[31:0]);
      vvlh_ff    <= 63'(pv_ff[31:0]) * 63'(pv_ff[62:32]);
      vvhh_ff    <= 62'(pv_ff[62:32]) * 62'(pv_ff[62:32]);
      p2_zero_ff <= (pu_ff == '0) && (pv_ff == '0);
      uu_ff      <= (128'(uuhh_ff) << 64) + (128'(uulh_ff) << 33) + 128'(uull_ff);
      vv_ff      <= (128'(vvhh_ff) << 64) + (128'(vvlh_ff) << 33) + 128'(vvll_ff);
      p3_zero_ff <= p2_zero_ff;
      dnum_ff    <= uu_ff;
      dden_ff    <= uu_ff + vv_ff;
      p4_zero_ff <= p3_zero_ff;
   end

   // weight division, one quotient bit a stage
   logic [127:0]       div_rem_ff [0:DIV_STEPS-1];
   logic [127:0]       div_den_ff [0:DIV_STEPS-1];
   logic [P_FRAC:0]    div_q_ff   [0:DIV_STEPS-1];
   logic [127:0]       div_rem_in [0:DIV_STEPS-1];
   logic [P_FRAC:0]    div_q_in   [0:DIV_STEPS-1];
   logic [DIV_STEPS-1:0] div_valid_ff;
   logic [DIV_STEPS-1:0] div_zero_ff;

   for (genvar gd = 0; gd < DIV_STEPS; gd++) begin : g_div
      logic [127:0]    rs, ds, rt;
      logic [P_FRAC:0] qs;
      logic            vs, zs;
      if (gd == 0) begin : g_head
         assign rs = dnum_ff;
         assign rt = rs;
         assign ds = dden_ff;
         assign qs = '0;
         assign vs = p4_valid_ff;
         assign zs = p4_zero_ff;
      end else begin : g_body
         assign rs = div_rem_ff[gd-1];
         assign rt = rs << 1;
         assign ds = div_den_ff[gd-1];
         assign qs = div_q_ff[gd-1];
         assign vs = div_valid_ff[gd-1];
         assign zs = div_zero_ff[gd-1];
      end
      always_comb begin
         if (rt >= ds) begin
            div_rem_in[gd] = rt - ds;
            div_q_in[gd]   = {qs[P_FRAC-1:0], 1'b1};
         end else begin
            div_rem_in[gd] = rt;
            div_q_in[gd]   = {qs[P_FRAC-1:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[gd] <= 1'b0;
         end else begin
            div_valid_ff[gd] <= vs;
         end
         div_zero_ff[gd] <= zs;
         div_rem_ff[gd]  <= div_rem_in[gd];
         div_den_ff[gd]  <= ds;
         div_q_ff[gd]    <= div_q_in[gd];
      end
   end

   // blend of the squared axes
   logic [P_FRAC:0]  wp, wq;
   logic [56:0]      mpa_ff [0:2];
   logic [56:0]      mpb_ff [0:2];
   logic             m1_valid_ff, m1_zero_ff;
   logic [104:0]     aap_ff, bbq_ff;
   logic             m2_valid_ff, m2_zero_ff;
   logic [105:0]     r2_sum;
   logic [R2_W-1:0]  r2_ff;
   logic             m3_valid_ff, m3_zero_ff;

   assign wp     = div_q_ff[LAST_DIV];
   assign wq     = (P_FRAC + 1)'(1) << P_FRAC;
   assign r2_sum = 106'(aap_ff) + 106'(bbq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= div_valid_ff[LAST_DIV];
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
      mpa_ff[0]  <= 57'(aa_ff[23:0])  * 57'(wp);
      mpa_ff[1]  <= 57'(aa_ff[47:24]) * 57'(wp);
      mpa_ff[2]  <= 57'(aa_ff[71:48]) * 57'(wp);
      mpb_ff[0]  <= 57'(bb_ff[23:0])  * 57'(wq - wp);
      mpb_ff[1]  <= 57'(bb_ff[47:24]) * 57'(wq - wp);
      mpb_ff[2]  <= 57'(bb_ff[71:48]) * 57'(wq - wp);
      m1_zero_ff <= div_zero_ff[LAST_DIV];
      aap_ff     <= 105'(mpa_ff[0]) + (105'(mpa_ff[1]) << 24) + (105'(mpa_ff[2]) << 48);
      bbq_ff     <= 105'(mpb_ff[0]) + (105'(mpb_ff[1]) << 24) + (105'(mpb_ff[2]) << 48);
      m2_zero_ff <= m1_zero_ff;
      r2_ff      <= r2_sum[R2_W+31:32];
      m3_zero_ff <= m2_zero_ff;
   end

   // square root, one root bit a stage
   logic [R2_W-1:0]       sq_rem_ff  [0:SQRT_STEPS-1];
   axis_type              sq_root_ff [0:SQRT_STEPS-1];
   logic [R2_W-1:0]       sq_rem_in  [0:SQRT_STEPS-1];
   axis_type              sq_root_in [0:SQRT_STEPS-1];
   logic [SQRT_STEPS-1:0] sq_valid_ff;
   logic [SQRT_STEPS-1:0] sq_zero_ff;

   for (genvar gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
      localparam int BIT = SQRT_STEPS - 1 - gk;
      logic [R2_W-1:0] rs;
      axis_type        ts;
      logic [R2_W+1:0] trial;
      logic            vs, zs;
      if (gk == 0) begin : g_head
         assign rs = r2_ff;
         assign ts = '0;
         assign vs = m3_valid_ff;
         assign zs = m3_zero_ff;
      end else begin : g_body
         assign rs = sq_rem_ff[gk-1];
         assign ts = sq_root_ff[gk-1];
         assign vs = sq_valid_ff[gk-1];
         assign zs = sq_zero_ff[gk-1];
      end
      assign trial = ((R2_W + 2)'(ts) << (BIT + 1)) + ((R2_W + 2)'(1) << (2 * BIT));
      always_comb begin
         if ((R2_W + 2)'(rs) >= trial) begin
            sq_rem_in[gk]  = R2_W'((R2_W + 2)'(rs) - trial);
            sq_root_in[gk] = ts | (AXIS_W'(1) << BIT);
         end else begin
            sq_rem_in[gk]  = rs;
            sq_root_in[gk] = ts;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[gk] <= 1'b0;
         end else begin
            sq_valid_ff[gk] <= vs;
         end
         sq_zero_ff[gk] <= zs;
         sq_rem_ff[gk]  <= sq_rem_in[gk];
         sq_root_ff[gk] <= sq_root_in[gk];
      end
   end

   // result register
   logic     out_error;
   q30_type  flat_field, ecc_field;
   logic     rsp_strobe_ff;
   axis_type rsp_radius_ff, rsp_radius_in;
   q30_type  rsp_flat_ff, rsp_flat_in;
   q30_type  rsp_ecc_ff, rsp_ecc_in;
   logic     rsp_error_ff;

   always_comb begin
      out_error = sq_zero_ff[LAST_SQRT] || (semi_major_ff == '0);
      if (flat_sat_ff) begin
         flat_field = neg_ff ? Q30_MIN : Q30_MAX;
      end else begin
         flat_field = neg_ff ? Q30_W'(0) - Q30_W'(flat_q_ff) : Q30_W'(flat_q_ff);
      end
      if (ecc_sat_ff) begin
         ecc_field = neg_ff ? Q30_MIN : Q30_MAX;
      end else begin
         ecc_field = neg_ff ? Q30_W'(0) - Q30_W'(ecc_q_ff) : Q30_W'(ecc_q_ff);
      end
      rsp_radius_in = out_error ? '0 : sq_root_ff[LAST_SQRT];
      rsp_flat_in   = out_error ? '0 : flat_field;
      rsp_ecc_in    = out_error ? '0 : ecc_field;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sq_valid_ff[LAST_SQRT];
      end
      rsp_radius_ff <= rsp_radius_in;
      rsp_flat_ff   <= rsp_flat_in;
      rsp_ecc_ff    <= rsp_ecc_in;
      rsp_error_ff  <= out_error;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_radius_mm       = rsp_radius_ff;
   assign rsp_flattening_q30  = rsp_flat_ff;
   assign rsp_ecc_squared_q30 = rsp_ecc_ff;
   assign rsp_math_error      = rsp_error_ff;

   // checks
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_error_ff |->
         rsp_radius_ff == '0 && rsp_flat_ff == '0 && rsp_ecc_ff == '0)
      else $error("error result carries nonzero fields");

   a_seq_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> seq_state_ff == SEQ_DONE)
      else $error("result shown before flattening sequencer finished");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> fold_valid_ff)
      else $error("accepted item missing from first stage");

endmodule
